// ===== rtl/tlbpt_pkg.sv =====
// tlbpt_pkg: shared types and constants for the tlb page table translator
// no dependencies; used by the interfaces, the tlb cell and the top level
package tlbpt_pkg;

  localparam int ADDR_W     = 16;  // logical and physical address fields
  localparam int EV_PAGE_W  = 8;   // evicted page field
  localparam int FC_W       = 9;   // frame_count register
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [FC_W-1:0] FRAME_COUNT_RESET = FC_W'(128);

  // register indexes on the configuration port
  typedef enum logic {
    REG_FRAME_COUNT = 1'b0
  } cfg_reg_t;

  // control handed to every tlb cell in the same cycle
  typedef struct packed {
    logic shift;  // new entry enters cell 0, every cell takes its left neighbor
    logic drop;   // invalidate entries holding drop_page
  } tlb_ctl_t;

endpackage

// ===== rtl/tlbpt_if.sv =====
// tlbpt_in_if / tlbpt_out_if: valid/ready channels of the translator
// depends on tlbpt_pkg for the field widths
interface tlbpt_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlbpt_pkg::ADDR_W-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

interface tlbpt_out_if;
  logic                           valid;
  logic                           ready;
  logic [tlbpt_pkg::ADDR_W-1:0]    physical_address;
  logic                           tlb_hit;
  logic                           page_fault;
  logic                           evicted_valid;
  logic [tlbpt_pkg::EV_PAGE_W-1:0] evicted_page;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output evicted_valid, output evicted_page,
                  input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, input evicted_valid, input evicted_page,
                output ready);
endinterface

// ===== rtl/tlbpt_ram.sv =====
// tlbpt_ram: generic single write port, single read port ram, registered read
// no dependencies
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tlbpt_cell.sv =====
// tlbpt_cell: one tlb entry; compares against the lookup page and shifts
// its entry to the right neighbor on insert. depends on tlbpt_pkg
module tlbpt_cell #(
  parameter int PAGE_BITS  = 8,
  parameter int FRAME_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tlbpt_pkg::tlb_ctl_t     ctl,
  input  logic [PAGE_BITS-1:0]    drop_page,
  input  logic [PAGE_BITS-1:0]    key,
  input  logic                    left_valid,
  input  logic [PAGE_BITS-1:0]    left_page,
  input  logic [FRAME_BITS-1:0]   left_frame,
  output logic                    valid,
  output logic [PAGE_BITS-1:0]    page,
  output logic [FRAME_BITS-1:0]   frame,
  output logic                    match
);

  logic                  valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  src_valid;

  always_comb begin
    src_valid = ctl.shift ? left_valid : valid_r;
    page_nxt  = ctl.shift ? left_page  : page_r;
    frame_nxt = ctl.shift ? left_frame : frame_r;
    valid_nxt = src_valid && !(ctl.drop && (page_nxt == drop_page));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
  end

  assign valid = valid_r;
  assign page  = page_r;
  assign frame = frame_r;
  assign match = valid_r && (page_r == key);

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// tlb_page_table_translator: tlb as a chain of cells, page table in rams,
// fifo frame replacement. depends on tlbpt_pkg, tlbpt_if, tlbpt_cell, tlbpt_ram
//
//   port      dir  handshake            carries
//   in_ch     in   valid/ready          logical_address
//   out_ch    out  valid/ready          physical_address, tlb_hit, page_fault,
//                                       evicted_valid, evicted_page
//   cfg_*     in   apb write/read       frame_count at byte address 0
//
// one translation at a time: a tlb hit steps through accept and compare, a
// miss through accept, compare and resolve, the extra step set by the
// registered reads of the page table and frame owner rams; the result is in
// the output register at the end of the last step.
// rst_n is synchronous; tlb, page table valid bits and counters clear at once.
// a result waits in the output register; a stalled out_ch holds the next
// translation in its last step, and in_ch.ready stays low until it leaves.
module tlb_page_table_translator #(
  parameter int PAGE_BITS   = 8,
  parameter int OFFSET_BITS = 8,
  parameter int TLB_ENTRIES = 16,
  parameter int MAX_FRAMES  = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tlbpt_in_if.sink                           in_ch,
  tlbpt_out_if.source                        out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tlbpt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tlbpt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tlbpt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int FB         = $clog2(MAX_FRAMES);
  localparam int AW         = PAGE_BITS + OFFSET_BITS;
  localparam int XW         = (AW > tlbpt_pkg::ADDR_W) ? AW : tlbpt_pkg::ADDR_W;
  localparam int PW         = (FB + OFFSET_BITS > tlbpt_pkg::ADDR_W) ?
                              FB + OFFSET_BITS : tlbpt_pkg::ADDR_W;
  localparam int CW         = (FB + 1 > tlbpt_pkg::FC_W) ? FB + 1 : tlbpt_pkg::FC_W;
  localparam int EXW        = (PAGE_BITS > tlbpt_pkg::EV_PAGE_W) ?
                              PAGE_BITS : tlbpt_pkg::EV_PAGE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RESOLVE
  } state_t;

  // configuration
  logic [tlbpt_pkg::FC_W-1:0] fc_r;
  logic                       cfg_wr;
  logic [CW-1:0]              fc_x;
  logic [FB:0]                limit;

  // transaction in flight
  state_t                 state_r, state_nxt;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [XW-1:0]          addr_x;

  // page table and replacement state
  logic [PAGE_COUNT-1:0]  map_valid_r;
  logic [FB:0]            frames_used_r;
  logic [FB-1:0]          oldest_r;
  logic [FB-1:0]          oldest_inc;

  // ram read data
  logic [PAGE_BITS-1:0]   owner_rd;
  logic [FB-1:0]          map_pg_rd;
  logic [FB-1:0]          map_ow_rd;

  // resolve step
  logic                   pt_hit;
  logic                   fresh;
  logic                   evict;
  logic [FB-1:0]          frame_res;
  logic                   commit;
  logic                   install;
  logic                   done;

  // tlb chain
  tlbpt_pkg::tlb_ctl_t    tlb_ctl;
  logic [TLB_ENTRIES-1:0] tlb_match;
  logic                   cell_valid [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   cell_page  [TLB_ENTRIES];
  logic [FB-1:0]          cell_frame [TLB_ENTRIES];
  logic                   tlb_hit_w;
  logic [FB-1:0]          hit_frame;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [tlbpt_pkg::ADDR_W-1:0]      out_pa_r, out_pa_nxt;
  logic                              out_hit_r, out_hit_nxt;
  logic                              out_fault_r, out_fault_nxt;
  logic                              out_ev_valid_r, out_ev_valid_nxt;
  logic [tlbpt_pkg::EV_PAGE_W-1:0]   out_ev_page_r, out_ev_page_nxt;
  logic [PW-1:0]                     pa_hit_x, pa_res_x;
  logic [EXW-1:0]                    ev_x;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == tlbpt_pkg::REG_FRAME_COUNT);

  always_comb begin
    if (cfg_paddr[2] == tlbpt_pkg::REG_FRAME_COUNT) begin
      cfg_prdata = tlbpt_pkg::CFG_DATA_W'(fc_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // zero acts as one, anything above the frame pool as the whole pool
  always_comb begin
    fc_x = CW'(fc_r);
    if (fc_x == '0) begin
      limit = (FB + 1)'(1);
    end else if (fc_x > CW'(MAX_FRAMES)) begin
      limit = (FB + 1)'(MAX_FRAMES);
    end else begin
      limit = fc_x[FB:0];
    end
  end

  // ---------------- tlb chain ----------------
  always_comb begin
    tlb_ctl.shift = install;
    tlb_ctl.drop  = commit && evict;
  end

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      tlbpt_cell #(.PAGE_BITS(PAGE_BITS), .FRAME_BITS(FB)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tlb_ctl),
        .drop_page  (owner_rd),
        .key        (page_r),
        .left_valid (1'b1),
        .left_page  (page_r),
        .left_frame (frame_res),
        .valid      (cell_valid[i]),
        .page       (cell_page[i]),
        .frame      (cell_frame[i]),
        .match      (tlb_match[i])
      );
    end else begin : g_body
      tlbpt_cell #(.PAGE_BITS(PAGE_BITS), .FRAME_BITS(FB)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tlb_ctl),
        .drop_page  (owner_rd),
        .key        (page_r),
        .left_valid (cell_valid[i-1]),
        .left_page  (cell_page[i-1]),
        .left_frame (cell_frame[i-1]),
        .valid      (cell_valid[i]),
        .page       (cell_page[i]),
        .frame      (cell_frame[i]),
        .match      (tlb_match[i])
      );
    end
  end

  // a page sits in the tlb at most once, so the matches can be or-ed
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | ({FB{tlb_match[i]}} & cell_frame[i]);
    end
  end
  assign tlb_hit_w = |tlb_match;

  // ---------------- page table rams ----------------
  // frame owner is read at the oldest frame all the time, so the owner
  // is registered by the compare step and can address the second map read
  tlbpt_ram #(.WIDTH(PAGE_BITS), .DEPTH(MAX_FRAMES)) u_owner_ram (
    .clk   (clk),
    .we    (install),
    .waddr (frame_res),
    .wdata (page_r),
    .raddr (oldest_r),
    .rdata (owner_rd)
  );

  tlbpt_ram #(.WIDTH(FB), .DEPTH(PAGE_COUNT)) u_map_pg_ram (
    .clk   (clk),
    .we    (install),
    .waddr (page_r),
    .wdata (frame_res),
    .raddr (page_r),
    .rdata (map_pg_rd)
  );

  tlbpt_ram #(.WIDTH(FB), .DEPTH(PAGE_COUNT)) u_map_ow_ram (
    .clk   (clk),
    .we    (install),
    .waddr (page_r),
    .wdata (frame_res),
    .raddr (owner_rd),
    .rdata (map_ow_rd)
  );

  // ---------------- resolve ----------------
  always_comb begin
    pt_hit     = map_valid_r[page_r];
    fresh      = frames_used_r < limit;
    evict      = !pt_hit && !fresh && map_valid_r[owner_rd] && (map_ow_rd == oldest_r);
    oldest_inc = oldest_r + FB'(1);
    if (pt_hit) begin
      frame_res = map_pg_rd;
    end else if (fresh) begin
      frame_res = frames_used_r[FB-1:0];
    end else begin
      frame_res = oldest_r;
    end
  end

  assign install = commit && !pt_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r          <= tlbpt_pkg::FRAME_COUNT_RESET;
      map_valid_r   <= '0;
      frames_used_r <= '0;
      oldest_r      <= '0;
    end else begin
      if (cfg_wr) begin
        fc_r <= cfg_pwdata[tlbpt_pkg::FC_W-1:0];
      end
      if (install) begin
        if (evict) begin
          map_valid_r[owner_rd] <= 1'b0;
        end
        map_valid_r[page_r] <= 1'b1;
        if (fresh) begin
          frames_used_r <= frames_used_r + (FB + 1)'(1);
        end else if (((FB + 1)'(oldest_r) + (FB + 1)'(1)) >= limit) begin
          oldest_r <= '0;
        end else begin
          oldest_r <= oldest_inc;
        end
      end
    end
  end

  // ---------------- sequencer and output register ----------------
  assign addr_x   = XW'(in_ch.logical_address);
  assign pa_hit_x = PW'({hit_frame, offset_r});
  assign pa_res_x = PW'({frame_res, offset_r});
  assign ev_x     = EXW'(owner_rd);
  assign done     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt        = state_r;
    commit           = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_pa_nxt       = out_pa_r;
    out_hit_nxt      = out_hit_r;
    out_fault_nxt    = out_fault_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!tlb_hit_w) begin
          state_nxt = S_RESOLVE;
        end else if (done) begin
          state_nxt        = S_IDLE;
          out_valid_nxt    = 1'b1;
          out_pa_nxt       = pa_hit_x[tlbpt_pkg::ADDR_W-1:0];
          out_hit_nxt      = 1'b1;
          out_fault_nxt    = 1'b0;
          out_ev_valid_nxt = 1'b0;
          out_ev_page_nxt  = '0;
        end
      end
      S_RESOLVE: begin
        if (done) begin
          state_nxt        = S_IDLE;
          commit           = 1'b1;
          out_valid_nxt    = 1'b1;
          out_pa_nxt       = pa_res_x[tlbpt_pkg::ADDR_W-1:0];
          out_hit_nxt      = 1'b0;
          out_fault_nxt    = !pt_hit;
          out_ev_valid_nxt = evict;
          out_ev_page_nxt  = evict ? ev_x[tlbpt_pkg::EV_PAGE_W-1:0] : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pa_r       <= out_pa_nxt;
    out_hit_r      <= out_hit_nxt;
    out_fault_r    <= out_fault_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    if (in_ch.valid && in_ch.ready) begin
      page_r   <= addr_x[OFFSET_BITS +: PAGE_BITS];
      offset_r <= addr_x[OFFSET_BITS-1:0];
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.physical_address = out_pa_r;
  assign out_ch.tlb_hit          = out_hit_r;
  assign out_ch.page_fault       = out_fault_r;
  assign out_ch.evicted_valid    = out_ev_valid_r;
  assign out_ch.evicted_page     = out_ev_page_r;

  // ---------------- assertions ----------------
  a_one_tlb_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tlb_match))
    else $error("page present in more than one tlb entry");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("tlb hit reported together with a page fault");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_valid_r) |-> out_fault_r)
    else $error("eviction reported without a page fault");

  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    frames_used_r <= (FB + 1)'(MAX_FRAMES))
    else $error("frames handed out beyond the frame pool");

  a_install_maps: assert property (@(posedge clk) disable iff (!rst_n)
    install |=> map_valid_r[$past(page_r)])
    else $error("faulted page not mapped after install");

endmodule

// ===== test/tlbpt_checker.sv =====
// tlbpt_checker: watches the translator channels and the config port, predicts each
// translation and compares it field by field. depends on tlbpt_pkg
module tlbpt_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [tlbpt_pkg::ADDR_W-1:0]     in_logical_address,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [tlbpt_pkg::ADDR_W-1:0]     out_physical_address,
  input  logic                             out_tlb_hit,
  input  logic                             out_page_fault,
  input  logic                             out_evicted_valid,
  input  logic [tlbpt_pkg::EV_PAGE_W-1:0]  out_evicted_page,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tlbpt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tlbpt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                             cfg_pready,
  output int                               fail_count,
  output int                               pending,
  output int                               xlate_count,
  output int                               hit_count,
  output int                               fault_count,
  output int                               evict_count
);

  localparam int ADDR_W     = tlbpt_pkg::ADDR_W;
  localparam int EV_PAGE_W  = tlbpt_pkg::EV_PAGE_W;
  localparam int FC_W       = tlbpt_pkg::FC_W;
  localparam int CFG_ADDR_W = tlbpt_pkg::CFG_ADDR_W;
  localparam int TLB_DEPTH  = 16;
  localparam int PAGE_COUNT = 256;
  localparam int FRAME_MAX  = 256;

  typedef struct packed {
    logic [ADDR_W-1:0]    physical_address;
    logic                 tlb_hit;
    logic                 page_fault;
    logic                 evicted_valid;
    logic [EV_PAGE_W-1:0] evicted_page;
  } xlate_t;

  // shadow of the translator state
  logic [FC_W-1:0] frame_count;
  logic            tlb_v  [TLB_DEPTH];
  logic [7:0]      tlb_pg [TLB_DEPTH];
  logic [7:0]      tlb_fr [TLB_DEPTH];
  logic [3:0]      tlb_next;
  logic            map_v  [PAGE_COUNT];
  logic [7:0]      map_fr [PAGE_COUNT];
  logic [7:0]      owner_of [FRAME_MAX];
  logic [8:0]      frames_used;
  logic [7:0]      oldest;

  xlate_t expected_xlates[$];
  int     errors, n_xlate, n_hit, n_fault, n_evict;

  function automatic xlate_t translate(input logic [ADDR_W-1:0] la);
    xlate_t     r;
    logic [7:0] pg, frm, owner;
    logic [8:0] lim;
    bit         found;
    int         i;
    r     = '0;
    pg    = la[15:8];
    frm   = '0;
    found = 1'b0;
    // lowest matching tlb slot wins
    for (i = 0; i < TLB_DEPTH; i++) begin
      if (!found && tlb_v[i] && tlb_pg[i] == pg) begin
        frm   = tlb_fr[i];
        found = 1'b1;
      end
    end
    if (found) begin
      r.tlb_hit = 1'b1;
    end else if (map_v[pg]) begin
      frm = map_fr[pg];
    end else begin
      r.page_fault = 1'b1;
      if (frame_count == 0) lim = 9'd1;
      else if (frame_count > 9'(FRAME_MAX)) lim = 9'(FRAME_MAX);
      else lim = frame_count;
      if (frames_used < lim) begin
        frm = frames_used[7:0];
        frames_used++;
      end else begin
        frm   = oldest;
        owner = owner_of[frm];
        // only unmap the owner if it still points at this frame
        if (map_v[owner] && map_fr[owner] == frm) begin
          map_v[owner] = 1'b0;
          for (i = 0; i < TLB_DEPTH; i++)
            if (tlb_v[i] && tlb_pg[i] == owner) tlb_v[i] = 1'b0;
          r.evicted_valid = 1'b1;
          r.evicted_page  = owner;
        end
        oldest = ({1'b0, frm} + 9'd1 >= lim) ? 8'd0 : frm + 8'd1;
      end
      owner_of[frm]    = pg;
      map_v[pg]        = 1'b1;
      map_fr[pg]       = frm;
      tlb_v[tlb_next]  = 1'b1;
      tlb_pg[tlb_next] = pg;
      tlb_fr[tlb_next] = frm;
      tlb_next++;
    end
    r.physical_address = {frm, la[7:0]};
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    n_xlate = 0;
    n_hit   = 0;
    n_fault = 0;
    n_evict = 0;
  end

  always @(posedge clk) begin
    xlate_t want, got;
    if (!rst_n) begin
      frame_count = tlbpt_pkg::FRAME_COUNT_RESET;
      tlb_next    = '0;
      frames_used = '0;
      oldest      = '0;
      for (int i = 0; i < TLB_DEPTH; i++) tlb_v[i] = 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        map_v[i]    = 1'b0;
        map_fr[i]   = '0;
        owner_of[i] = '0;
      end
      expected_xlates.delete();
    end else begin
      // writes to unused register slots are dropped
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == tlbpt_pkg::REG_FRAME_COUNT)
        frame_count = cfg_pwdata[FC_W-1:0];

      if (out_valid && out_ready) begin
        got = {out_physical_address, out_tlb_hit, out_page_fault,
               out_evicted_valid, out_evicted_page};
        if (expected_xlates.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got pa=0x%0h", $time,
                   out_physical_address);
          errors++;
        end else begin
          want = expected_xlates.pop_front();
          check_field("physical_address", 32'(want.physical_address),
                      32'(got.physical_address));
          check_field("tlb_hit", 32'(want.tlb_hit), 32'(got.tlb_hit));
          check_field("page_fault", 32'(want.page_fault), 32'(got.page_fault));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
        end
      end

      if (in_valid && in_ready) begin
        want = translate(in_logical_address);
        expected_xlates.push_back(want);
        n_xlate++;
        n_hit   += 32'(want.tlb_hit);
        n_fault += 32'(want.page_fault);
        n_evict += 32'(want.evicted_valid);
      end
    end
    fail_count  <= errors;
    pending     <= expected_xlates.size();
    xlate_count <= n_xlate;
    hit_count   <= n_hit;
    fault_count <= n_fault;
    evict_count <= n_evict;
  end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for tlb_page_table_translator
// depends on tlbpt_pkg, tlbpt_if, the translator rtl and tlbpt_checker
module tb;

  localparam int ADDR_W       = tlbpt_pkg::ADDR_W;
  localparam int FC_W         = tlbpt_pkg::FC_W;
  localparam int CFG_ADDR_W   = tlbpt_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W   = tlbpt_pkg::CFG_DATA_W;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 300;
  localparam logic [CFG_ADDR_W-1:0] FRAME_COUNT_ADDR = {tlbpt_pkg::REG_FRAME_COUNT, 2'b00};
  // slot one past frame_count, nothing lives there
  localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR = FRAME_COUNT_ADDR + 3'd4;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;

  int fail_count, pending, xlate_count, hit_count, fault_count, evict_count;
  int cycle_count;
  bit quiet;
  bit hold_req;

  tlbpt_in_if  in_ch ();
  tlbpt_out_if out_ch ();

  tlb_page_table_translator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tlbpt_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_ch.valid),
    .in_ready             (in_ch.ready),
    .in_logical_address   (in_ch.logical_address),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_physical_address (out_ch.physical_address),
    .out_tlb_hit          (out_ch.tlb_hit),
    .out_page_fault       (out_ch.page_fault),
    .out_evicted_valid    (out_ch.evicted_valid),
    .out_evicted_page     (out_ch.evicted_page),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_pready           (cfg_pready),
    .fail_count           (fail_count),
    .pending              (pending),
    .xlate_count          (xlate_count),
    .hit_count            (hit_count),
    .fault_count          (fault_count),
    .evict_count          (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random ready bursts, one long hold on request, steady at the end
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_address(input logic [ADDR_W-1:0] la);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.logical_address <= la;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait for every outstanding translation to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly a hot window of pages for tlb and page table reuse, some scattered pages
  function automatic logic [ADDR_W-1:0] next_address(input logic [7:0] base,
                                                      input int spread);
    logic [7:0] pg;
    if ($urandom_range(0, 9) < 2) pg = 8'($urandom);
    else pg = base + 8'($urandom_range(0, spread - 1));
    return {pg, 8'($urandom)};
  endfunction

  task automatic run_phase(input logic [FC_W-1:0] fc, input int count, input int spread);
    logic [7:0] base;
    base = 8'($urandom);
    write_reg(FRAME_COUNT_ADDR, CFG_DATA_W'(fc));
    repeat (count) send_address(next_address(base, spread));
    drain();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.logical_address <= '0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: address extremes, tlb hits, then enough pages to push early ones
    // out of the tlb so they come back from the page table
    send_address(16'h0000);
    send_address(16'h0000);
    send_address(16'hffff);
    send_address(16'hff00);
    send_address(16'h00ff);
    for (int p = 1; p <= 17; p++)
      send_address({8'(p), (p % 2 == 1) ? 8'h55 : 8'haa});
    send_address(16'h0042);
    send_address(16'hff7f);
    drain();

    // a write to the spare slot must leave frame_count alone
    write_reg(SPARE_REG_ADDR, CFG_DATA_W'(1));
    run_phase(9'd4, 70, 6);
    run_phase(9'd0, 40, 3);
    hold_req = 1'b1;
    run_phase(9'd511, 70, 40);
    run_phase(9'd256, 70, 200);
    run_phase(9'd3, 60, 8);
    quiet = 1'b1;
    run_phase(9'd200, 70, 20);
    repeat (8) @(posedge clk);

    $display("ran %0d translations: %0d tlb hits, %0d page faults, %0d evictions",
             xlate_count, hit_count, fault_count, evict_count);
    $display("frame_count swept over 128, 4, 0, 511, 256, 3 and 200 with random stalls");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
